FILE: design/rc_channel_frame_packer_macros.svh
// Assertion macros used by the frame packer top-level design file.
`ifndef RC_CHANNEL_FRAME_PACKER_MACROS_SVH
`define RC_CHANNEL_FRAME_PACKER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RCFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rcfp_pkg.sv
// Package with the types, constants and CRC function of the frame packer.
package rcfp_pkg;

  localparam int unsigned UsWidth       = 16;
  localparam int unsigned TickWidth     = 11;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned ChanIdxWidth  = 4;
  localparam int unsigned ResBitsWidth  = 7;
  localparam int unsigned ResCntWidth   = 3;
  localparam int unsigned BufDepth      = 4;
  localparam int unsigned BufPtrWidth   = 2;
  localparam int unsigned BufCntWidth   = 3;

  localparam logic [ByteWidth-1:0]    AddrReset   = 8'hC8;
  localparam logic [ByteWidth-1:0]    FrameLength = 8'd24;
  localparam logic [ByteWidth-1:0]    FrameType   = 8'h16;
  localparam logic [ByteWidth-1:0]    CrcPoly     = 8'hD5;
  localparam logic [ChanIdxWidth-1:0] FirstChan   = 4'd0;
  localparam logic [ChanIdxWidth-1:0] LastChan    = 4'd15;

  // Pulse width centre and tick centre of the conversion.
  localparam logic [UsWidth:0]     UsCentre   = 17'd1500;
  localparam logic [TickWidth-1:0] TickCentre = 11'd992;
  // ceil(2^21 / 5): exact quotient by five for magnitudes below 699050.
  localparam int unsigned          RecipShift = 21;
  localparam logic [18:0]          RecipFive  = 19'd419431;

  // One byte of the outgoing stream with its framing flags.
  typedef struct packed {
    logic [ByteWidth-1:0] data;
    logic                 end_of_item;
    logic                 end_of_frame;
  } entry_t;

  // CRC-8, polynomial 0xD5, MSB first, over one byte.
  function automatic logic [ByteWidth-1:0] crc_update(input logic [ByteWidth-1:0] crc,
                                                      input logic [ByteWidth-1:0] data);
    logic [ByteWidth-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after the type byte, the start value for the payload of every frame.
  localparam logic [ByteWidth-1:0] CrcAfterType = crc_update(8'h00, FrameType);

endpackage

FILE: design/rcfp_intf.sv
// Handshake interfaces for the channel, byte and configuration ports.
interface rcfp_chan_if import rcfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [UsWidth-1:0] channel_us;
  modport source (output valid, output channel_us, input ready);
  modport sink (input valid, input channel_us, output ready);
endinterface

interface rcfp_byte_if import rcfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] out_byte;
  logic                 end_of_item;
  logic                 end_of_frame;
  modport source (output valid, output out_byte, output end_of_item, output end_of_frame,
                  input ready);
  modport sink (input valid, input out_byte, input end_of_item, input end_of_frame,
                output ready);
endinterface

interface rcfp_cfg_if import rcfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] frame_address;
  modport source (output valid, output frame_address, input ready);
  modport sink (input valid, input frame_address, output ready);
endinterface

FILE: design/rc_channel_frame_packer.sv
// Top level of the radio-control channel frame packer.
// A channel request passes stages A, B and C before its first byte is shown.
// Throughput: one byte per cycle on the output port while it is ready. A request causes
// four bytes for channel 1, three for channel 16 and one or two otherwise, so a frame
// of 16 requests gives 26 bytes.
// Reset clears all control state and sets the frame address to 0xC8 at once.
`include "rc_channel_frame_packer_macros.svh"

module rc_channel_frame_packer
  import rcfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rcfp_chan_if.sink  chan_i,
  rcfp_cfg_if.sink   cfg_i,
  rcfp_byte_if.source byte_o
);

  // The design is a three-stage pipeline. Stage A registers the raw pulse width.
  // Stage B holds the 11-bit tick value, produced by one reciprocal multiplication.
  // Stage C is a four-entry byte buffer: a tick value is packed, the CRC is advanced
  // and all bytes it causes are written at once, then drained one per cycle while
  // the output is ready. Stage C reloads in the same cycle that its last byte is taken,
  // so the output never idles while requests are waiting.

  // Configuration register, always ready. Users write it only while idle; unenforced.
  logic [ByteWidth-1:0] addr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= AddrReset;
    end else if (cfg_i.valid) begin
      addr_q <= cfg_i.frame_address;
    end
  end

  // Handshake control of the three stages.
  logic                   a_valid_q, b_valid_q;
  logic [BufCntWidth-1:0] cnt_q;
  logic [BufPtrWidth-1:0] rd_ptr_q;
  logic                   take, c_free, c_load, b_free, a_move, a_free, in_take;

  assign take    = (cnt_q != '0) && byte_o.ready;
  assign c_free  = (cnt_q == '0) || ((cnt_q == BufCntWidth'(1)) && byte_o.ready);
  assign c_load  = b_valid_q && c_free;
  assign b_free  = !b_valid_q || c_free;
  assign a_move  = a_valid_q && b_free;
  assign a_free  = !a_valid_q || b_free;
  assign in_take = chan_i.valid && a_free;

  assign chan_i.ready = a_free;

  // Stage A: raw pulse width.
  logic [UsWidth-1:0] us_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_take) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      us_q <= chan_i.channel_us;
    end
  end

  // Tick conversion: ((us - 1500) * 8) / 5 + 992, quotient truncated toward zero.
  // The division runs on the magnitude and the sign is put back afterwards, which
  // gives truncation toward zero. Only the low 11 bits are kept, so they wrap.
  logic [UsWidth:0]       diff;
  logic                   diff_neg;
  logic [UsWidth-1:0]     diff_mag;
  logic [18:0]            scaled;
  logic [37:0]            prod;
  logic [TickWidth-1:0]   quot;
  logic [TickWidth-1:0]   ticks_d;

  always_comb begin
    diff     = {1'b0, us_q} - UsCentre;
    diff_neg = diff[UsWidth];
    diff_mag = diff_neg ? UsWidth'(-diff) : diff[UsWidth-1:0];
    scaled   = {diff_mag, 3'b000};
    prod     = 38'(scaled) * 38'(RecipFive);
    quot     = prod[RecipShift+TickWidth-1:RecipShift];
    ticks_d  = (diff_neg ? TickWidth'(-quot) : quot) + TickCentre;
  end

  // Stage B: tick value.
  logic [TickWidth-1:0] ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      ticks_q <= ticks_d;
    end
  end

  // Frame state carried from one channel to the next.
  logic [ChanIdxWidth-1:0] chan_idx_q;
  logic [ResBitsWidth-1:0] res_bits_q;
  logic [ResCntWidth-1:0]  res_cnt_q;
  logic [ByteWidth-1:0]    crc_q;

  // Packing of one tick value. At most 18 bits are pending, so one or two whole
  // payload bytes leave and at most seven bits stay behind.
  logic                    first, last, two_bytes;
  logic [ResBitsWidth-1:0] rb;
  logic [ResCntWidth-1:0]  rc;
  logic [17:0]             acc;
  logic [4:0]              nbits;
  logic [ByteWidth-1:0]    p0, p1, crc_base, crc_one, crc_two, crc_d;
  logic [ResBitsWidth-1:0] res_bits_d;
  logic [ResCntWidth-1:0]  res_cnt_d;
  entry_t                  ent_d [BufDepth];
  logic [BufCntWidth-1:0]  n_d;

  always_comb begin
    first     = (chan_idx_q == FirstChan);
    last      = (chan_idx_q == LastChan);
    rb        = first ? '0 : res_bits_q;
    rc        = first ? '0 : res_cnt_q;
    acc       = 18'(rb) | (18'(ticks_q) << rc);
    nbits     = 5'(rc) + 5'(TickWidth);
    two_bytes = nbits[4];
    p0        = acc[7:0];
    p1        = acc[15:8];
    crc_base  = first ? CrcAfterType : crc_q;
    crc_one   = crc_update(crc_base, p0);
    crc_two   = crc_update(crc_one, p1);
    crc_d     = two_bytes ? crc_two : crc_one;
    if (two_bytes) begin
      res_bits_d = ResBitsWidth'(acc[17:16]);
      res_cnt_d  = ResCntWidth'(nbits - 5'd16);
    end else begin
      res_bits_d = acc[14:8];
      res_cnt_d  = ResCntWidth'(nbits - 5'd8);
    end

    for (int i = 0; i < BufDepth; i++) begin
      ent_d[i] = '{data: '0, end_of_item: 1'b0, end_of_frame: 1'b0};
    end

    if (first) begin
      // The first channel of a frame never holds two whole bytes, nor the CRC.
      ent_d[0] = '{data: addr_q,      end_of_item: 1'b0, end_of_frame: 1'b0};
      ent_d[1] = '{data: FrameLength, end_of_item: 1'b0, end_of_frame: 1'b0};
      ent_d[2] = '{data: FrameType,   end_of_item: 1'b0, end_of_frame: 1'b0};
      ent_d[3] = '{data: p0,          end_of_item: 1'b1, end_of_frame: 1'b0};
      n_d      = BufCntWidth'(4);
    end else if (two_bytes) begin
      ent_d[0] = '{data: p0, end_of_item: 1'b0,  end_of_frame: 1'b0};
      ent_d[1] = '{data: p1, end_of_item: !last, end_of_frame: 1'b0};
      ent_d[2] = '{data: crc_d, end_of_item: 1'b1, end_of_frame: 1'b1};
      n_d      = last ? BufCntWidth'(3) : BufCntWidth'(2);
    end else begin
      ent_d[0] = '{data: p0,    end_of_item: !last, end_of_frame: 1'b0};
      ent_d[1] = '{data: crc_d, end_of_item: 1'b1,  end_of_frame: 1'b1};
      n_d      = last ? BufCntWidth'(2) : BufCntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_idx_q <= '0;
      res_bits_q <= '0;
      res_cnt_q  <= '0;
      crc_q      <= '0;
    end else if (c_load) begin
      chan_idx_q <= last ? FirstChan : chan_idx_q + ChanIdxWidth'(1);
      res_bits_q <= last ? '0 : res_bits_d;
      res_cnt_q  <= last ? '0 : res_cnt_d;
      crc_q      <= crc_d;
    end
  end

  // Stage C: byte buffer, drained in order by the read pointer.
  entry_t buf_q [BufDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_ptr_q <= '0;
    end else if (c_load) begin
      cnt_q    <= n_d;
      rd_ptr_q <= '0;
    end else if (take) begin
      cnt_q    <= cnt_q - BufCntWidth'(1);
      rd_ptr_q <= rd_ptr_q + BufPtrWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_load) begin
      buf_q <= ent_d;
    end
  end

  assign byte_o.valid        = (cnt_q != '0);
  assign byte_o.out_byte     = buf_q[rd_ptr_q].data;
  assign byte_o.end_of_item  = buf_q[rd_ptr_q].end_of_item;
  assign byte_o.end_of_frame = buf_q[rd_ptr_q].end_of_frame;

  `RCFP_ASSERT_NEXT(a_hdr_load, c_load && first, (cnt_q == BufCntWidth'(4)) && (rd_ptr_q == '0), "header load must fill all four buffer entries")
  `RCFP_ASSERT_NEXT(a_last_load, c_load && last, (chan_idx_q == FirstChan) && (cnt_q == BufCntWidth'(3)), "closing channel must end with three bytes and restart the frame")
  `RCFP_ASSERT_NEXT(a_b_hold, b_valid_q && !c_free, b_valid_q && $stable(ticks_q), "stalled tick value must be held")
  `RCFP_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= BufCntWidth'(BufDepth), "buffer count beyond depth")

endmodule
